// File: hdl/ibmi_pkg.sv
`timescale 1ns / 1ps
// constants, types and divider step functions for the inode block map index unit
// no dependencies; used by inode_block_map_index_unit
package ibmi_pkg;

   // fixed field widths
   localparam int BLK_W    = 40;   // logical block number
   localparam int BS_W     = 17;   // block size register
   localparam int SLOT_W   = 11;   // one slot index, also handles per block
   localparam int SQ_W     = 2 * SLOT_W;   // handles squared
   localparam int DIV_W    = 3 * SLOT_W;   // handles cubed, first dividend
   localparam int LEVEL_W  = 3;
   localparam int CSR_W    = 32;
   localparam int ADDR_W   = 2;

   // direct slots held in the inode
   localparam int DIRECT_SLOTS = 8;

   // handles per indirect block = (block_size - 100) / 40
   localparam logic [BS_W-1:0] BS_RESET    = BS_W'(8192);
   localparam logic [BS_W-1:0] BS_MAX      = BS_W'(65536);
   localparam logic [BS_W-1:0] BS_OVERHEAD = BS_W'(100);
   localparam int HANDLE_BYTES = 20 * 2;
   // x / 40 == (x * RECIP_MUL) >> RECIP_SHIFT for every 16 bit x
   localparam int RECIP_SHIFT  = 21;
   localparam int RECIP_W      = 16;
   localparam logic [RECIP_W-1:0] RECIP_MUL =
      RECIP_W'(((1 << RECIP_SHIFT) + HANDLE_BYTES - 1) / HANDLE_BYTES);

   // divider pipeline shape
   localparam int STAGE_BITS = 3;
   localparam int D1_STAGES  = DIV_W / STAGE_BITS;
   localparam int D2_STAGES  = (SQ_W + STAGE_BITS - 1) / STAGE_BITS;
   localparam int D2_BITS    = D2_STAGES * STAGE_BITS;
   localparam int PIPE_LAST  = D1_STAGES + D2_STAGES;

   // register map
   localparam logic [ADDR_W-1:0] CSR_BLOCK_SIZE = ADDR_W'(0);

   typedef enum logic [LEVEL_W-1:0] {
      LVL_DIRECT = 3'd0,
      LVL_SINGLE = 3'd1,
      LVL_DOUBLE = 3'd2,
      LVL_TRIPLE = 3'd3,
      LVL_RANGE  = 3'd4
   } level_type;

   // partial remainder and shifting dividend / quotient word
   typedef struct packed {
      logic [SLOT_W-1:0] rem;
      logic [DIV_W-1:0]  num;
   } div_state_type;

   typedef struct packed {
      level_type         level;
      logic [SLOT_W-1:0] low_slot;   // direct or single-level slot
      div_state_type     div;
      logic [SLOT_W-1:0] r1;         // off mod nfh
      logic [SLOT_W-1:0] q1;         // low bits of off / nfh
   } pipe_type;

   // one restoring shift-subtract step
   function automatic div_state_type div_step(div_state_type s, logic [SLOT_W-1:0] dvs);
      logic [SLOT_W:0] trial;
      div_state_type   r;
      trial = {s.rem, s.num[DIV_W-1]};
      r.num = {s.num[DIV_W-2:0], 1'b0};
      if (trial >= {1'b0, dvs}) begin
         r.rem    = SLOT_W'(trial - {1'b0, dvs});
         r.num[0] = 1'b1;
      end else begin
         r.rem = trial[SLOT_W-1:0];
      end
      return r;
   endfunction

   // quotient bits retired by one pipeline stage
   function automatic div_state_type div_stage(div_state_type s, logic [SLOT_W-1:0] dvs);
      div_state_type r;
      r = s;
      for (int b = 0; b < STAGE_BITS; b++) begin
         r = div_step(r, dvs);
      end
      return r;
   endfunction

endpackage

// File: hdl/inode_block_map_index_unit.sv
`timescale 1ns / 1ps
// inode block map index unit: classifies a logical block and splits it into slot indices
// throughput: one beat per cycle while busy is low; the two chained divisions by the
// handle count retire 3 quotient bits per stage (11 stages for the first, 8 for the second)
// reset and every block_size write hold busy high while the handle count, its square,
// its cube and the level bounds are formed; reset loads 8192
// results cannot be stalled by the receiver
// depends on ibmi_pkg
module inode_block_map_index_unit (
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          start,
   output logic                          busy,
   input  logic [ibmi_pkg::BLK_W-1:0]    req_logical_block,
   // result channel
   output logic                          rsp_valid,
   output logic [ibmi_pkg::LEVEL_W-1:0]  rsp_map_level,
   output logic [ibmi_pkg::SLOT_W-1:0]   rsp_first_slot,
   output logic [ibmi_pkg::SLOT_W-1:0]   rsp_second_slot,
   output logic [ibmi_pkg::SLOT_W-1:0]   rsp_third_slot,
   // register port
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [ibmi_pkg::ADDR_W-1:0]   paddr,
   input  logic [ibmi_pkg::CSR_W-1:0]    pwdata,
   output logic [ibmi_pkg::CSR_W-1:0]    prdata,
   output logic                          pready
);

   typedef enum logic [2:0] {
      SU_NFH,
      SU_SQUARE,
      SU_CUBE,
      SU_BOUND,
      SU_READY
   } setup_type;

   setup_type                      setup_ff;
   logic [ibmi_pkg::BS_W-1:0]      bs_ff;
   logic [ibmi_pkg::SLOT_W-1:0]    nfh_ff;
   logic [ibmi_pkg::SQ_W-1:0]      n2_ff;
   logic [ibmi_pkg::DIV_W-1:0]     n3_ff;
   logic [ibmi_pkg::SLOT_W:0]      lim1_ff;
   logic [ibmi_pkg::SQ_W:0]        lim2_ff;
   logic [ibmi_pkg::DIV_W:0]       lim3_ff;

   logic                           csr_write;
   logic [ibmi_pkg::BS_W-1:0]      bs_sat;
   logic [ibmi_pkg::RECIP_W-1:0]   bs_net;
   logic [2*ibmi_pkg::RECIP_W-1:0] recip_prod;
   logic [ibmi_pkg::SLOT_W-1:0]    nfh_in;

   logic                           accept;
   logic [ibmi_pkg::BLK_W-1:0]     offset;
   ibmi_pkg::pipe_type             entry;

   logic                           valid_ff [0:ibmi_pkg::PIPE_LAST];
   ibmi_pkg::pipe_type             pipe_ff  [0:ibmi_pkg::PIPE_LAST];
   ibmi_pkg::pipe_type             pipe_in  [1:ibmi_pkg::PIPE_LAST];
   ibmi_pkg::pipe_type             fin;

   logic                           rsp_valid_ff;
   logic [ibmi_pkg::LEVEL_W-1:0]   rsp_level_ff;
   logic [ibmi_pkg::SLOT_W-1:0]    rsp_first_ff;
   logic [ibmi_pkg::SLOT_W-1:0]    rsp_second_ff;
   logic [ibmi_pkg::SLOT_W-1:0]    rsp_third_ff;
   logic [ibmi_pkg::LEVEL_W-1:0]   rsp_level_in;
   logic [ibmi_pkg::SLOT_W-1:0]    rsp_first_in;
   logic [ibmi_pkg::SLOT_W-1:0]    rsp_second_in;
   logic [ibmi_pkg::SLOT_W-1:0]    rsp_third_in;

   // register port
   assign pready    = 1'b1;
   assign csr_write = psel & penable & pwrite & (paddr == ibmi_pkg::CSR_BLOCK_SIZE);
   assign prdata    = (paddr == ibmi_pkg::CSR_BLOCK_SIZE) ?
                      ibmi_pkg::CSR_W'(bs_ff) : '0;

   // handle count from block size, saturated above and clamped below
   always_comb begin
      bs_sat = (bs_ff > ibmi_pkg::BS_MAX) ? ibmi_pkg::BS_MAX : bs_ff;
      if (bs_sat < ibmi_pkg::BS_OVERHEAD) begin
         bs_net = '0;
      end else begin
         bs_net = ibmi_pkg::RECIP_W'(bs_sat - ibmi_pkg::BS_OVERHEAD);
      end
      recip_prod = bs_net * ibmi_pkg::RECIP_MUL;
      nfh_in     = recip_prod[ibmi_pkg::RECIP_SHIFT +: ibmi_pkg::SLOT_W];
   end

   // setup sequencer: one product per cycle after reset or a block size write
   always_ff @(posedge clock) begin
      if (reset) begin
         setup_ff <= SU_NFH;
         bs_ff    <= ibmi_pkg::BS_RESET;
      end else if (csr_write) begin
         setup_ff <= SU_NFH;
         bs_ff    <= pwdata[ibmi_pkg::BS_W-1:0];
      end else begin
         case (setup_ff)
            SU_NFH: begin
               nfh_ff   <= nfh_in;
               setup_ff <= SU_SQUARE;
            end
            SU_SQUARE: begin
               n2_ff    <= nfh_ff * nfh_ff;
               lim1_ff  <= (ibmi_pkg::SLOT_W + 1)'(ibmi_pkg::DIRECT_SLOTS) +
                           (ibmi_pkg::SLOT_W + 1)'(nfh_ff);
               setup_ff <= SU_CUBE;
            end
            SU_CUBE: begin
               n3_ff    <= ibmi_pkg::DIV_W'(n2_ff) * ibmi_pkg::DIV_W'(nfh_ff);
               lim2_ff  <= (ibmi_pkg::SQ_W + 1)'(ibmi_pkg::DIRECT_SLOTS) +
                           (ibmi_pkg::SQ_W + 1)'(n2_ff);
               setup_ff <= SU_BOUND;
            end
            SU_BOUND: begin
               lim3_ff  <= (ibmi_pkg::DIV_W + 1)'(ibmi_pkg::DIRECT_SLOTS) +
                           (ibmi_pkg::DIV_W + 1)'(n3_ff);
               setup_ff <= SU_READY;
            end
            SU_READY: begin
               setup_ff <= SU_READY;
            end
            default: begin
               setup_ff <= SU_NFH;
            end
         endcase
      end
   end

   assign busy   = (setup_ff != SU_READY);
   assign accept = start & ~busy;

   // level classification of the incoming beat
   always_comb begin
      offset         = req_logical_block - ibmi_pkg::BLK_W'(ibmi_pkg::DIRECT_SLOTS);
      entry          = '0;
      entry.level    = ibmi_pkg::LVL_RANGE;
      if (req_logical_block < ibmi_pkg::BLK_W'(ibmi_pkg::DIRECT_SLOTS)) begin
         entry.level    = ibmi_pkg::LVL_DIRECT;
         entry.low_slot = req_logical_block[ibmi_pkg::SLOT_W-1:0];
      end else if (req_logical_block < ibmi_pkg::BLK_W'(lim1_ff)) begin
         entry.level    = ibmi_pkg::LVL_SINGLE;
         entry.low_slot = offset[ibmi_pkg::SLOT_W-1:0];
      end else if (req_logical_block < ibmi_pkg::BLK_W'(lim2_ff)) begin
         entry.level    = ibmi_pkg::LVL_DOUBLE;
         entry.div.num  = offset[ibmi_pkg::DIV_W-1:0];
      end else if (req_logical_block < ibmi_pkg::BLK_W'(lim3_ff)) begin
         entry.level    = ibmi_pkg::LVL_TRIPLE;
         entry.div.num  = offset[ibmi_pkg::DIV_W-1:0];
      end
   end

   // divider stages: off / nfh first, then that quotient / nfh
   always_comb begin
      ibmi_pkg::pipe_type p;
      for (int i = 0; i < ibmi_pkg::PIPE_LAST; i++) begin
         p = pipe_ff[i];
         if (i == ibmi_pkg::D1_STAGES) begin
            p.r1      = p.div.rem;
            p.q1      = p.div.num[ibmi_pkg::SLOT_W-1:0];
            p.div.rem = '0;
            p.div.num = ibmi_pkg::DIV_W'({p.div.num[ibmi_pkg::SQ_W-1:0],
                        {(ibmi_pkg::DIV_W - ibmi_pkg::D2_BITS){1'b0}}});
         end
         p.div        = ibmi_pkg::div_stage(p.div, nfh_ff);
         pipe_in[i+1] = p;
      end
   end

   // pipeline registers; valid bits travel beside the payload
   always_ff @(posedge clock) begin
      pipe_ff[0] <= entry;
      for (int i = 1; i <= ibmi_pkg::PIPE_LAST; i++) begin
         pipe_ff[i] <= pipe_in[i];
      end
      if (reset) begin
         for (int i = 0; i <= ibmi_pkg::PIPE_LAST; i++) begin
            valid_ff[i] <= 1'b0;
         end
      end else begin
         valid_ff[0] <= accept;
         for (int i = 1; i <= ibmi_pkg::PIPE_LAST; i++) begin
            valid_ff[i] <= valid_ff[i-1];
         end
      end
   end

   // slot selection by level
   assign fin = pipe_ff[ibmi_pkg::PIPE_LAST];

   always_comb begin
      rsp_level_in  = fin.level;
      rsp_first_in  = '0;
      rsp_second_in = '0;
      rsp_third_in  = '0;
      case (fin.level)
         ibmi_pkg::LVL_DIRECT, ibmi_pkg::LVL_SINGLE: begin
            rsp_first_in = fin.low_slot;
         end
         ibmi_pkg::LVL_DOUBLE: begin
            rsp_first_in  = fin.q1;
            rsp_second_in = fin.r1;
         end
         ibmi_pkg::LVL_TRIPLE: begin
            rsp_first_in  = fin.div.num[ibmi_pkg::SLOT_W-1:0];
            rsp_second_in = fin.div.rem;
            rsp_third_in  = fin.r1;
         end
         default: begin
            rsp_level_in = ibmi_pkg::LVL_RANGE;
         end
      endcase
   end

   // result beat register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= valid_ff[ibmi_pkg::PIPE_LAST];
      end
      rsp_level_ff  <= rsp_level_in;
      rsp_first_ff  <= rsp_first_in;
      rsp_second_ff <= rsp_second_in;
      rsp_third_ff  <= rsp_third_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_map_level   = rsp_level_ff;
   assign rsp_first_slot  = rsp_first_ff;
   assign rsp_second_slot = rsp_second_ff;
   assign rsp_third_slot  = rsp_third_ff;

endmodule

// File: tb/tb_inode_block_map_index_unit.sv
`timescale 1ns / 1ps
// testbench for inode_block_map_index_unit: level boundaries, then random blocks over
// many block sizes, each result beat checked against a predicted slot map
// depends on ibmi_pkg and inode_block_map_index_unit
module tb_inode_block_map_index_unit;

   localparam int LIMIT       = 400000;
   localparam int TAIL        = 30;
   localparam int PHASES      = 12;
   localparam int PHASE_BEATS = 170;
   localparam int MAP_DEPTH   = 64;
   localparam logic [ibmi_pkg::BLK_W-1:0] BLK_ONES = '1;

   typedef struct {
      ibmi_pkg::level_type         level;
      logic [ibmi_pkg::SLOT_W-1:0] first_slot;
      logic [ibmi_pkg::SLOT_W-1:0] second_slot;
      logic [ibmi_pkg::SLOT_W-1:0] third_slot;
   } slot_map_type;

   // predicted slot maps, oldest first, under the block size last written
   class slot_map_board;
      logic [ibmi_pkg::BS_W-1:0] block_size;
      slot_map_type              due_maps[MAP_DEPTH];
      int                        head_idx;
      int                        tail_idx;
      int                        due_count;
      int                        fail_count;

      function new();
         block_size = ibmi_pkg::BS_RESET;
         head_idx   = 0;
         tail_idx   = 0;
         due_count  = 0;
         fail_count = 0;
      endfunction

      // number of maps still waiting for their result beat
      function int pending();
         return due_count;
      endfunction

      // handles per indirect block, size saturated at the top
      function longint unsigned handles();
         logic [ibmi_pkg::BS_W-1:0] bs;
         bs = (block_size > ibmi_pkg::BS_MAX) ? ibmi_pkg::BS_MAX : block_size;
         if (bs < ibmi_pkg::BS_OVERHEAD) return 0;
         return (bs - ibmi_pkg::BS_OVERHEAD) / ibmi_pkg::HANDLE_BYTES;
      endfunction

      function slot_map_type predict_map(logic [ibmi_pkg::BLK_W-1:0] blk);
         longint unsigned nfh, sq, cube, offs;
         slot_map_type m;
         nfh  = handles();
         sq   = nfh * nfh;
         cube = sq * nfh;
         m.level       = ibmi_pkg::LVL_RANGE;
         m.first_slot  = '0;
         m.second_slot = '0;
         m.third_slot  = '0;
         if (blk < ibmi_pkg::DIRECT_SLOTS) begin
            m.level      = ibmi_pkg::LVL_DIRECT;
            m.first_slot = ibmi_pkg::SLOT_W'(blk);
         end else begin
            // every indirect level counts from the first non-direct block
            offs = longint'(blk) - ibmi_pkg::DIRECT_SLOTS;
            if (offs < nfh) begin
               m.level      = ibmi_pkg::LVL_SINGLE;
               m.first_slot = ibmi_pkg::SLOT_W'(offs);
            end else if (offs < sq) begin
               m.level       = ibmi_pkg::LVL_DOUBLE;
               m.first_slot  = ibmi_pkg::SLOT_W'(offs / nfh);
               m.second_slot = ibmi_pkg::SLOT_W'(offs % nfh);
            end else if (offs < cube) begin
               m.level       = ibmi_pkg::LVL_TRIPLE;
               m.first_slot  = ibmi_pkg::SLOT_W'(offs / sq);
               m.second_slot = ibmi_pkg::SLOT_W'((offs % sq) / nfh);
               m.third_slot  = ibmi_pkg::SLOT_W'(offs % nfh);
            end
         end
         return m;
      endfunction

      function void log_block(logic [ibmi_pkg::BLK_W-1:0] blk);
         if (due_count == MAP_DEPTH) begin
            $error("too many request beats in flight");
            fail_count++;
            return;
         end
         due_maps[tail_idx] = predict_map(blk);
         tail_idx = (tail_idx + 1) % MAP_DEPTH;
         due_count++;
      endfunction

      function void check_map(logic [ibmi_pkg::LEVEL_W-1:0] lvl,
                              logic [ibmi_pkg::SLOT_W-1:0] s1,
                              logic [ibmi_pkg::SLOT_W-1:0] s2,
                              logic [ibmi_pkg::SLOT_W-1:0] s3);
         slot_map_type m;
         if (due_count == 0) begin
            $error("result beat with no block pending");
            fail_count++;
            return;
         end
         m = due_maps[head_idx];
         head_idx = (head_idx + 1) % MAP_DEPTH;
         due_count--;
         if (lvl !== m.level) begin
            $error("map_level: expected %0d, got %0d", m.level, lvl);
            fail_count++;
         end
         if (s1 !== m.first_slot) begin
            $error("first_slot: expected %0d, got %0d", m.first_slot, s1);
            fail_count++;
         end
         if (s2 !== m.second_slot) begin
            $error("second_slot: expected %0d, got %0d", m.second_slot, s2);
            fail_count++;
         end
         if (s3 !== m.third_slot) begin
            $error("third_slot: expected %0d, got %0d", m.third_slot, s3);
            fail_count++;
         end
      endfunction
   endclass

   logic                              clock = 1'b0;
   logic                              reset;
   logic                              start;
   logic                              busy;
   logic [ibmi_pkg::BLK_W-1:0]        req_logical_block;
   logic                              rsp_valid;
   logic [ibmi_pkg::LEVEL_W-1:0]      rsp_map_level;
   logic [ibmi_pkg::SLOT_W-1:0]       rsp_first_slot;
   logic [ibmi_pkg::SLOT_W-1:0]       rsp_second_slot;
   logic [ibmi_pkg::SLOT_W-1:0]       rsp_third_slot;
   logic                              psel;
   logic                              penable;
   logic                              pwrite;
   logic [ibmi_pkg::ADDR_W-1:0]       paddr;
   logic [ibmi_pkg::CSR_W-1:0]        pwdata;
   logic [ibmi_pkg::CSR_W-1:0]        prdata;
   logic                              pready;
   int                                cycles = 0;
   slot_map_board                     board = new();

   inode_block_map_index_unit dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_logical_block (req_logical_block),
      .rsp_valid         (rsp_valid),
      .rsp_map_level     (rsp_map_level),
      .rsp_first_slot    (rsp_first_slot),
      .rsp_second_slot   (rsp_second_slot),
      .rsp_third_slot    (rsp_third_slot),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // accepted request beats and result beats, sampled at the edge
   always @(posedge clock) begin
      if (!reset && start && !busy) begin
         board.log_block(req_logical_block);
      end
      if (!reset && rsp_valid) begin
         board.check_map(rsp_map_level, rsp_first_slot, rsp_second_slot, rsp_third_slot);
      end
   end

   // run limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // block at a level boundary: 0, last direct, then first and last of each level
   function automatic logic [ibmi_pkg::BLK_W-1:0] bound_block(int idx,
                                                             longint unsigned nfh);
      longint unsigned sq, cube;
      sq   = nfh * nfh;
      cube = sq * nfh;
      case (idx)
         0: return '0;
         1: return ibmi_pkg::BLK_W'(ibmi_pkg::DIRECT_SLOTS - 1);
         2: return ibmi_pkg::BLK_W'(ibmi_pkg::DIRECT_SLOTS);
         3: return ibmi_pkg::BLK_W'(ibmi_pkg::DIRECT_SLOTS + nfh - 1);
         4: return ibmi_pkg::BLK_W'(ibmi_pkg::DIRECT_SLOTS + nfh);
         5: return ibmi_pkg::BLK_W'(ibmi_pkg::DIRECT_SLOTS + sq - 1);
         6: return ibmi_pkg::BLK_W'(ibmi_pkg::DIRECT_SLOTS + sq);
         7: return ibmi_pkg::BLK_W'(ibmi_pkg::DIRECT_SLOTS + cube - 1);
         8: return ibmi_pkg::BLK_W'(ibmi_pkg::DIRECT_SLOTS + cube);
         default: return BLK_ONES;
      endcase
   endfunction

   // spread over the levels, near the boundaries, and over all 40 bits
   function automatic logic [ibmi_pkg::BLK_W-1:0] random_block(longint unsigned nfh);
      longint unsigned sq, cube, r;
      int pick;
      sq   = nfh * nfh;
      cube = sq * nfh;
      r    = {$urandom, $urandom};
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
         return ibmi_pkg::BLK_W'($urandom_range(0, ibmi_pkg::DIRECT_SLOTS - 1));
      end
      if (nfh >= 2) begin
         if (pick < 30) return ibmi_pkg::BLK_W'(ibmi_pkg::DIRECT_SLOTS + r % nfh);
         if (pick < 50) begin
            return ibmi_pkg::BLK_W'(ibmi_pkg::DIRECT_SLOTS + nfh + r % (sq - nfh));
         end
         if (pick < 70) begin
            return ibmi_pkg::BLK_W'(ibmi_pkg::DIRECT_SLOTS + sq + r % (cube - sq));
         end
      end
      if (pick < 85) begin
         return ibmi_pkg::BLK_W'(bound_block($urandom_range(0, 9), nfh) +
                                 $urandom_range(0, 6) - 3);
      end
      return ibmi_pkg::BLK_W'(r);
   endfunction

   // one request beat, each cycle before it idle with the given odds
   task automatic send_block(input logic [ibmi_pkg::BLK_W-1:0] blk, input int idle_pct);
      while ($urandom_range(0, 99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start             <= 1'b1;
      req_logical_block <= blk;
      do @(posedge clock); while (busy);
   endtask

   // hold requests until every predicted map has come back
   task automatic wait_maps_done();
      start <= 1'b0;
      @(posedge clock);
      while (board.pending() != 0) @(posedge clock);
   endtask

   // write block_size, then read it back
   task automatic write_block_size(input logic [ibmi_pkg::BS_W-1:0] bs);
      logic [ibmi_pkg::CSR_W-1:0] word;
      word = ibmi_pkg::CSR_W'(bs);
      if ($urandom_range(0, 1)) begin
         word[ibmi_pkg::CSR_W-1:ibmi_pkg::BS_W] =
            (ibmi_pkg::CSR_W - ibmi_pkg::BS_W)'($urandom);
      end
      while (busy) @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= ibmi_pkg::CSR_BLOCK_SIZE;
      pwdata  <= word;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      board.block_size = bs;
      // read access
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== ibmi_pkg::CSR_W'(bs)) begin
         $error("block_size: expected %0d, got %0d", bs, prdata);
         board.fail_count++;
      end
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   initial begin
      logic [ibmi_pkg::BS_W-1:0] bs;
      int idle_pct;
      reset             <= 1'b1;
      start             <= 1'b0;
      req_logical_block <= '0;
      psel              <= 1'b0;
      penable           <= 1'b0;
      pwrite            <= 1'b0;
      paddr             <= '0;
      pwdata            <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // reset block size: every level boundary and the largest block
      for (int k = 0; k <= 9; k++) send_block(bound_block(k, board.handles()), 0);
      wait_maps_done();
      // too small for one handle: everything past the direct slots is out of range
      write_block_size(ibmi_pkg::BS_W'(139));
      for (int k = 1; k <= 2; k++) send_block(bound_block(k, board.handles()), 0);
      send_block(BLK_ONES, 0);
      wait_maps_done();
      // one handle per indirect block
      write_block_size(ibmi_pkg::BS_W'(140));
      for (int k = 2; k <= 8; k += 2) send_block(bound_block(k, board.handles()), 0);
      wait_maps_done();
      // largest size, then a saturated one, at the top of the triple level
      write_block_size(ibmi_pkg::BS_MAX);
      for (int k = 7; k <= 8; k++) send_block(bound_block(k, board.handles()), 0);
      wait_maps_done();
      write_block_size('1);
      for (int k = 7; k <= 8; k++) send_block(bound_block(k, board.handles()), 0);
      wait_maps_done();
      // size below the per-block overhead
      write_block_size('0);
      send_block(bound_block(2, board.handles()), 0);

      // random phases, one block size each
      for (int p = 0; p < PHASES; p++) begin
         wait_maps_done();
         case (p)
            0:       bs = ibmi_pkg::BS_MAX;
            1:       bs = ibmi_pkg::BS_W'(180);
            2:       bs = '1;
            3:       bs = ibmi_pkg::BS_W'(139);
            4:       bs = ibmi_pkg::BS_W'(140);
            5:       bs = ibmi_pkg::BS_W'($urandom_range(141, 65536));
            6:       bs = '0;
            7:       bs = ibmi_pkg::BS_W'(1100);
            8:       bs = ibmi_pkg::BS_W'($urandom_range(0, 131071));
            9:       bs = ibmi_pkg::BS_W'(220);
            10:      bs = ibmi_pkg::BS_W'(65535);
            default: bs = ibmi_pkg::BS_W'($urandom_range(140, 4000));
         endcase
         write_block_size(bs);
         idle_pct = (p < 4) ? 18 : (p < 8) ? 47 : 0;
         for (int i = 0; i < PHASE_BEATS; i++) begin
            if (i == PHASE_BEATS / 2 && p % 3 == 0) wait_maps_done();
            send_block(random_block(board.handles()), idle_pct);
         end
      end

      wait_maps_done();
      repeat (TAIL) @(posedge clock);
      if (board.fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
